/* hdl/sdes_pkg.sv */
// Shared types, register indexes and S-DES permutation/substitution functions.
// Used by the core, the top level, the checker and tb_top; depends on nothing else.
package sdes_pkg;

    localparam int KEY_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int HALF_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEY_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] k_first;
        logic [BYTE_W-1:0] k_second;
    } sdes_keys_t;

    // row 0 and column 0 sit in the top bits
    localparam logic [0:3][0:3][1:0] SBOX0 = {
        {2'd1, 2'd0, 2'd3, 2'd2},
        {2'd3, 2'd2, 2'd1, 2'd0},
        {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd3, 2'd1, 2'd3, 2'd2}
    };
    localparam logic [0:3][0:3][1:0] SBOX1 = {
        {2'd0, 2'd1, 2'd2, 2'd3},
        {2'd2, 2'd0, 2'd1, 2'd3},
        {2'd3, 2'd0, 2'd1, 2'd0},
        {2'd2, 2'd1, 2'd0, 2'd3}
    };

    function automatic logic [KEY_W-1:0] perm_p10(input logic [KEY_W-1:0] k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic logic [BYTE_W-1:0] perm_p8(input logic [KEY_W-1:0] k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic logic [BYTE_W-1:0] perm_ip(input logic [BYTE_W-1:0] x);
        return {x[6], x[2], x[5], x[7], x[4], x[0], x[3], x[1]};
    endfunction

    function automatic logic [BYTE_W-1:0] perm_ipi(input logic [BYTE_W-1:0] x);
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    function automatic logic [1:0] sbox_look(input logic sel, input logic [NIB_W-1:0] a);
        logic [1:0] row;
        logic [1:0] col;
        row = {a[3], a[0]};
        col = {a[2], a[1]};
        return sel ? SBOX1[row][col] : SBOX0[row][col];
    endfunction

    // One Feistel round: expand right nibble, mix key, substitute, P4, fold into left.
    function automatic logic [BYTE_W-1:0] round_fk(input logic [BYTE_W-1:0] x,
                                                   input logic [BYTE_W-1:0] sk);
        logic [NIB_W-1:0]  r;
        logic [BYTE_W-1:0] e;
        logic [NIB_W-1:0]  s;
        logic [NIB_W-1:0]  p;
        r = x[3:0];
        e = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ sk;
        s = {sbox_look(1'b0, e[7:4]), sbox_look(1'b1, e[3:0])};
        p = {s[2], s[0], s[1], s[3]};
        return {x[7:4] ^ p, r};
    endfunction

    function automatic sdes_keys_t make_subkeys(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0]  k;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        sdes_keys_t        ks;
        k  = perm_p10(key);
        hi = {k[8:5], k[9]};
        lo = {k[3:0], k[4]};
        ks.k_first = perm_p8({hi, lo});
        hi = {hi[2:0], hi[4:3]};
        lo = {lo[2:0], lo[4:3]};
        ks.k_second = perm_p8({hi, lo});
        return ks;
    endfunction

endpackage

/* hdl/sdes_core.sv */
// Single-pass S-DES block transform: IP, round, swap, round, inverse IP.
// Depends on sdes_pkg for the permutation and round functions.
module sdes_core (
    input  logic [sdes_pkg::BYTE_W-1:0] data_in,
    input  sdes_pkg::sdes_keys_t        keys,
    output logic [sdes_pkg::BYTE_W-1:0] data_out
);
    import sdes_pkg::*;

    logic [BYTE_W-1:0] after_ip;
    logic [BYTE_W-1:0] after_r1;
    logic [BYTE_W-1:0] after_r2;

    always_comb begin
        after_ip = perm_ip(data_in);
        after_r1 = round_fk(after_ip, keys.k_first);
        // swap nibbles between rounds
        after_r2 = round_fk({after_r1[3:0], after_r1[7:4]}, keys.k_second);
        data_out = perm_ipi(after_r2);
    end

endmodule

/* hdl/sdes_byte_cipher_ecb_cbc.sv */
// Top level of the S-DES byte cipher with ECB and CBC modes.
// Depends on sdes_pkg and sdes_core.

// One byte in, one byte out, one transaction per clock sustained while
// m_ready keeps the result register free. A byte waits in the input
// register, passes the two cipher rounds and the chaining XOR as one
// combinational pass, and lands in the result register, which raises
// m_valid. The one-per-clock rate holds because the CBC chain loop,
// from the chain register through both rounds and back, holds no
// register but the chain register itself. Subkeys are derived
// when cipher_key is written and held in registers. Configuration writes
// take effect at once and belong to idle periods between messages; a byte
// with s_start_of_message set reloads the chain from init_vector first.
// The chain always follows the ciphertext, in ECB mode too, so switching
// to CBC mid-stream chains on from the last ciphertext byte.
module sdes_byte_cipher_ecb_cbc (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [sdes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdes_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sdes_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_start_of_message,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sdes_pkg::BYTE_W-1:0]       m_result_byte
);
    import sdes_pkg::*;

    // configuration state
    sdes_keys_t        keys_reg;
    logic              chain_mode_reg;
    logic              decrypt_reg;
    logic [BYTE_W-1:0] init_vector_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_som_reg;

    // result register and chain
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] chain_reg;

    logic              advance;
    logic [BYTE_W-1:0] chain_base;
    logic [BYTE_W-1:0] cipher_in;
    logic [BYTE_W-1:0] cipher_out;
    logic [BYTE_W-1:0] result_next;
    logic [BYTE_W-1:0] chain_next;
    sdes_keys_t        round_keys;

    // Result register frees up when empty or being drained this cycle.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign m_valid       = out_valid_reg;
    assign m_result_byte = out_data_reg;

    always_comb begin
        // reload chain at message start, ahead of this byte
        chain_base = in_som_reg ? init_vector_reg : chain_reg;
        // decryption runs the subkeys in reverse order
        round_keys.k_first  = decrypt_reg ? keys_reg.k_second : keys_reg.k_first;
        round_keys.k_second = decrypt_reg ? keys_reg.k_first  : keys_reg.k_second;
        // CBC encrypt: whiten plaintext with the chain before the rounds
        cipher_in = (chain_mode_reg && !decrypt_reg) ? (in_data_reg ^ chain_base)
                                                     : in_data_reg;
    end

    sdes_core u_core (
        .data_in  (cipher_in),
        .keys     (round_keys),
        .data_out (cipher_out)
    );

    always_comb begin
        // CBC decrypt: unwhiten after the rounds
        result_next = (chain_mode_reg && decrypt_reg) ? (cipher_out ^ chain_base)
                                                      : cipher_out;
        // chain follows the ciphertext side in either direction
        chain_next = decrypt_reg ? in_data_reg : cipher_out;
    end

    // control and configuration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg        <= make_subkeys('0);
            chain_mode_reg  <= 1'b0;
            decrypt_reg     <= 1'b0;
            init_vector_reg <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            chain_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CIPHER_KEY:  keys_reg        <= make_subkeys(cfg_wdata[KEY_W-1:0]);
                    CFG_CHAIN_MODE:  chain_mode_reg  <= cfg_wdata[0];
                    CFG_DECRYPT:     decrypt_reg     <= cfg_wdata[0];
                    CFG_INIT_VECTOR: init_vector_reg <= cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    chain_reg <= chain_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_som_reg  <= s_start_of_message;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= result_next;
        end
    end

endmodule

/* hdl/sdes_checker.sv */
// Port-level checker for sdes_byte_cipher_ecb_cbc, with its bind statement.
// Depends on sdes_pkg for field widths.
module sdes_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sdes_pkg::BYTE_W-1:0] m_result_byte
);
    import sdes_pkg::*;

    // a stalled result holds its value
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_byte));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");

    // reset empties the result register
    property p_reset_empty;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty) else $error("m_valid after reset");

    // back-pressure on input only when a result is waiting
    property p_ready_cause;
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid;
    endproperty
    a_ready_cause: assert property (p_ready_cause) else $error("s_ready low with no result");

    // input stalls only while output is stalled
    property p_ready_needs_stall;
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !m_ready;
    endproperty
    a_ready_needs_stall: assert property (p_ready_needs_stall)
        else $error("s_ready low while output drains");

endmodule

bind sdes_byte_cipher_ecb_cbc sdes_checker u_sdes_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_byte (m_result_byte)
);

/* verif/tb_top.sv */
// Testbench for the S-DES byte cipher in ECB and CBC modes.
// Checks each result byte against an in-bench cipher predictor.
// Depends on sdes_pkg and the sdes_byte_cipher_ecb_cbc top level.
`timescale 1ns / 1ps

module tb_top;
    import sdes_pkg::*;

    // Mode and direction codes of the chain_mode and decrypt registers
    localparam logic MODE_ECB = 1'b0;
    localparam logic MODE_CBC = 1'b1;
    localparam logic DIR_ENC  = 1'b0;
    localparam logic DIR_DEC  = 1'b1;

    // Permutation tables, one nibble per entry, first entry in the top nibble.
    // Entries are 1-based bit positions counted from the MSB of the input.
    localparam logic [39:0] P10_TAB = 40'h35274A1986;
    localparam logic [39:0] P8_TAB  = 40'h637485A900;
    localparam logic [39:0] IP_TAB  = 40'h2631485700;
    localparam logic [39:0] IPI_TAB = 40'h4135728600;
    localparam logic [39:0] EP_TAB  = 40'h4123234100;
    localparam logic [39:0] P4_TAB  = 40'h2431000000;

    // S-boxes, row-major, two bits per entry, entry 0 in the top bits
    localparam logic [31:0] S0_PACKED = 32'h4EE427DE;
    localparam logic [31:0] S1_PACKED = 32'h1B87C493;

    localparam time RUN_LIMIT = 5_000_000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_data_byte = '0;
    logic                   s_start_of_message = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_result_byte;

    // Shadow copy of the configuration and the chain register
    logic [KEY_W-1:0]       key_q = '0;
    logic                   mode_q = MODE_ECB;
    logic                   dir_q = DIR_ENC;
    logic [BYTE_W-1:0]      iv_q = '0;
    logic [BYTE_W-1:0]      chain_q = '0;

    logic [BYTE_W-1:0]      cipher_bytes_due[$];
    logic [BYTE_W-1:0]      due_byte;

    int unsigned            err_count = 0;
    int unsigned            bytes_sent = 0;
    int unsigned            bytes_checked = 0;
    int unsigned            settings_used = 0;

    // Idle control: a calm stretch turns off gaps and stalls on its side
    bit                     src_calm = 1'b0;
    bit                     sink_calm = 1'b0;
    int unsigned            sink_hold = 0;
    int unsigned            sink_roll;

    sdes_byte_cipher_ecb_cbc u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_message (s_start_of_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_byte      (m_result_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    // Gather n bits of an in_w-bit value in table order, MSB first.
    function automatic logic [9:0] remap_bits(input logic [9:0] x, input int in_w,
                                              input logic [39:0] tab, input int n);
        logic [9:0] r;
        int         pos;
        r = '0;
        for (int i = 0; i < n; i++) begin
            pos = int'(tab[(9 - i) * 4 +: 4]);
            r = {r[8:0], x[in_w - pos]};
        end
        return r;
    endfunction

    function automatic logic [4:0] rot5(input logic [4:0] x, input int n);
        logic [9:0] w;
        w = {x, x} << n;
        return w[9:5];
    endfunction

    // Row from the outer bits, column from the inner two.
    function automatic logic [1:0] sbox_pick(input logic [31:0] box, input logic [3:0] a);
        int idx;
        idx = {a[3], a[0]} * 4 + a[2:1];
        return box[31 - 2 * idx -: 2];
    endfunction

    function automatic logic [7:0] feistel_round(input logic [7:0] x, input logic [7:0] sk);
        logic [9:0] t;
        logic [7:0] e;
        logic [3:0] s;
        t = remap_bits({6'b0, x[3:0]}, 4, EP_TAB, 8);
        e = t[7:0] ^ sk;
        s = {sbox_pick(S0_PACKED, e[7:4]), sbox_pick(S1_PACKED, e[3:0])};
        t = remap_bits({6'b0, s}, 4, P4_TAB, 4);
        return {x[7:4] ^ t[3:0], x[3:0]};
    endfunction

    // Returns {subkey 1, subkey 2}.
    function automatic logic [15:0] derive_subkeys(input logic [9:0] key);
        logic [9:0] k;
        logic [4:0] hi;
        logic [4:0] lo;
        logic [9:0] k1;
        logic [9:0] k2;
        k  = remap_bits(key, 10, P10_TAB, 10);
        hi = rot5(k[9:5], 1);
        lo = rot5(k[4:0], 1);
        k1 = remap_bits({hi, lo}, 10, P8_TAB, 8);
        hi = rot5(hi, 2);
        lo = rot5(lo, 2);
        k2 = remap_bits({hi, lo}, 10, P8_TAB, 8);
        return {k1[7:0], k2[7:0]};
    endfunction

    function automatic logic [7:0] run_sdes(input logic [7:0] x, input logic [7:0] ka,
                                            input logic [7:0] kb);
        logic [9:0] t;
        logic [7:0] y;
        t = remap_bits({2'b0, x}, 8, IP_TAB, 8);
        y = feistel_round(t[7:0], ka);
        y = {y[3:0], y[7:4]};
        y = feistel_round(y, kb);
        t = remap_bits({2'b0, y}, 8, IPI_TAB, 8);
        return t[7:0];
    endfunction

    // Advance the shadow chain by one byte and return the byte the block owes.
    // The chain follows the ciphertext in both modes.
    function automatic logic [7:0] cipher_next_byte(input logic [7:0] data, input logic som);
        logic [15:0] keys;
        logic [7:0]  plain;
        logic [7:0]  r;
        if (som)
            chain_q = iv_q;
        keys = derive_subkeys(key_q);
        if (dir_q == DIR_ENC) begin
            plain = (mode_q == MODE_CBC) ? (data ^ chain_q) : data;
            r = run_sdes(plain, keys[15:8], keys[7:0]);
            chain_q = r;
        end else begin
            plain = run_sdes(data, keys[7:0], keys[15:8]);
            r = (mode_q == MODE_CBC) ? (plain ^ chain_q) : plain;
            chain_q = data;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the checker
    // ------------------------------------------------------------------

    // Hold m_ready for a random number of cycles, mostly high, with short
    // stalls and the odd long one.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_calm) begin
            m_ready <= 1'b1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 70) begin
                m_ready   <= 1'b1;
                sink_hold <= $urandom_range(0, 5);
            end else if (sink_roll < 95) begin
                m_ready   <= 1'b0;
                sink_hold <= $urandom_range(0, 3);
            end else begin
                m_ready   <= 1'b0;
                sink_hold <= $urandom_range(8, 40);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("[%0t] MISMATCH %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
        err_count++;
    endtask

    // Compare every accepted result transaction with the oldest byte due.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_bytes_due.size() == 0) begin
                report_mismatch("result with nothing due", 8'h00, m_result_byte);
            end else begin
                due_byte = cipher_bytes_due.pop_front();
                if (m_result_byte !== due_byte)
                    report_mismatch($sformatf("result_byte #%0d", bytes_checked),
                                    due_byte, m_result_byte);
                bytes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one byte and hold it until the transaction completes. Valid is
    // left high so a back-to-back byte can follow in the same step.
    task automatic send_byte(input logic [7:0] data, input logic som);
        s_valid            <= 1'b1;
        s_data_byte        <= data;
        s_start_of_message <= som;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        cipher_bytes_due.push_back(cipher_next_byte(data, som));
        bytes_sent++;
    endtask

    // Drop valid for a random gap: mostly none, some short, a few long.
    task automatic idle_gap();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        if (src_calm || roll < 60)
            return;
        n = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drop valid and wait until every byte due has come back, plus the
    // pipeline depth, so a register write lands on an idle block.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cipher_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // One register write; spare upper data bits carry random junk, which
    // the narrow registers must drop. Write enable drops again after the write.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] value);
        logic [CFG_DATA_W-1:0] wd;
        wd = CFG_DATA_W'($urandom());
        case (idx)
            CFG_CIPHER_KEY:  wd = value;
            CFG_CHAIN_MODE:  wd[0] = value[0];
            CFG_DECRYPT:     wd[0] = value[0];
            CFG_INIT_VECTOR: wd[7:0] = value[7:0];
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wd;
        @(posedge aclk);
        cfg_we <= 1'b0;
        // Every 2-bit index names a register, so no write is ever ignored.
        case (idx)
            CFG_CIPHER_KEY:  key_q = wd;
            CFG_CHAIN_MODE:  mode_q = wd[0];
            CFG_DECRYPT:     dir_q = wd[0];
            CFG_INIT_VECTOR: iv_q = wd[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic program_cipher(input logic [9:0] key, input logic mode, input logic dir,
                                  input logic [7:0] iv);
        drain();
        set_reg(CFG_CIPHER_KEY, key);
        set_reg(CFG_CHAIN_MODE, {9'b0, mode});
        set_reg(CFG_DECRYPT, {9'b0, dir});
        set_reg(CFG_INIT_VECTOR, {2'b0, iv});
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Chain a fresh message with no start mark: the chain is zero after reset
    // and the key keeps its reset value.
    task automatic test_chain_from_reset();
        set_reg(CFG_CHAIN_MODE, {9'b0, MODE_CBC});
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Codebook at the key extremes and the textbook key, both directions.
    // In ECB the start mark still loads the chain from init_vector.
    task automatic test_ecb_keys();
        program_cipher(10'b1010000010, MODE_ECB, DIR_ENC, 8'h00);
        send_byte(8'h97, 1'b0);
        send_byte(8'h00, 1'b1);
        program_cipher(10'h3FF, MODE_ECB, DIR_ENC, 8'hFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        program_cipher(10'h000, MODE_ECB, DIR_DEC, 8'h00);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Chained messages with restarts, in both directions.
    task automatic test_cbc_messages();
        program_cipher(10'b1010000010, MODE_CBC, DIR_ENC, 8'hFF);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hAA, 1'b1);
        program_cipher(10'b1010000010, MODE_CBC, DIR_DEC, 8'hFF);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
    endtask

    // Switch mode and then direction between bytes of one message; the
    // chain carries on from the last ciphertext byte.
    task automatic test_mode_switch();
        program_cipher(10'h155, MODE_ECB, DIR_ENC, 8'h3C);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        drain();
        set_reg(CFG_CHAIN_MODE, {9'b0, MODE_CBC});
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        drain();
        set_reg(CFG_DECRYPT, {9'b0, DIR_DEC});
        send_byte(8'h55, 1'b0);
    endtask

    // Random settings, each followed by random messages. Most messages are
    // well formed (start mark on the first byte only); the rest scatter
    // start marks at random.
    task automatic test_random_messages();
        int unsigned phase_start;
        int unsigned len;
        bit          well_formed;
        bit          calm;
        logic [9:0]  key;
        logic [7:0]  iv;
        logic        mode;
        logic        dir;
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 5))
                0:       key = 10'h000;
                1:       key = 10'h3FF;
                default: key = 10'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 3))
                0:       iv = 8'h00;
                1:       iv = 8'hFF;
                default: iv = 8'($urandom_range(0, 255));
            endcase
            // The first four phases walk every mode and direction pair
            mode = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
            dir  = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            program_cipher(key, mode, dir, iv);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 100) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                well_formed = $urandom_range(0, 99) < 85;
                calm = $urandom_range(0, 9) < 2;
                src_calm  = calm;
                sink_calm = calm;
                for (int j = 0; j < len; j++) begin
                    send_byte(8'($urandom_range(0, 255)),
                              well_formed ? (j == 0) : 1'($urandom_range(0, 1)));
                    idle_gap();
                end
            end
            src_calm  = 1'b0;
            sink_calm = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_chain_from_reset();
        test_ecb_keys();
        test_cbc_messages();
        test_mode_switch();
        test_random_messages();

        drain();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes and checked %0d results over %0d register settings,",
                 bytes_sent, bytes_checked, settings_used);
        $display("covering ECB and CBC in both directions with %0d mismatches.", err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Stop a hung run well past the slowest legal finish.
    initial begin
        #(RUN_LIMIT);
        $display("Timeout with %0d results still due", cipher_bytes_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
